/* hw/rtl/gpe_pkg.sv */
// Shared constants for the gait phase estimator.
`default_nettype none

package gpe_pkg;

    localparam int PRESS_W     = 16;
    localparam int TIME_W      = 32;
    localparam int PHASE_W     = 15;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 56;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_THR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_THR = 1'b1;

    localparam logic [PRESS_W-1:0] LOWER_THR_RST = 16'd19661;
    localparam logic [PRESS_W-1:0] UPPER_THR_RST = 16'd32768;

    localparam logic [PHASE_W-1:0] PHASE_FULL = 15'd25600;

    // 25600 = 25 * 2^10: scale by 25, then 5 integer and 10 fraction quotient bits
    localparam int PHASE_SCALE = 25;
    localparam int SCALE_W     = 5;
    localparam int DIV_STEPS   = PHASE_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int REM_W       = TIME_W + SCALE_W;

endpackage

`default_nettype wire

/* hw/rtl/gait_phase_estimator.sv */
// Gait phase estimator: hysteresis contact detector, strike timing and serial phase divider.
//
// Input items arrive on the s_ stream: tdata holds pressure (bits 15:0, unsigned 0.16)
// and time_ms (bits 47:16). Each accepted item yields one result item on the m_ stream:
// phase (14:0, percent with 8 fraction bits), contact (15), strike (16) and
// step_period_ms (48:17). Thresholds are written through cfg_wr_en / cfg_index /
// cfg_wdata; the user must write them only while the block is idle, which the block
// itself does not enforce. Index 0 is the release level, index 1 the strike level.
// The accepting edge registers the contact decision and elapsed time; the LOAD state
// scales by 25, a radix-2 restoring divider in the DIV state produces the 15 phase bits
// one quotient bit at a time, and the DONE state loads the output register and raises
// m_tvalid. Saturated cases skip the divider and go from LOAD straight to DONE.
// s_tready is high only while no item is in work. A finished result waits in the
// output register while the receiver stalls; the next item is still accepted, and its
// result is held back until the register frees.
// Reset (synchronous, active low) restores the default thresholds, clears contact,
// strike time and step period, and empties the output register.
`default_nettype none

module gait_phase_estimator (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [gpe_pkg::S_TDATA_W-1:0]    s_tdata,   // pressure, time_ms
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [gpe_pkg::M_TDATA_W-1:0]         m_tdata,   // phase, contact, strike, step_period_ms
    input  wire logic                             cfg_wr_en,
    input  wire logic [gpe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gpe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import gpe_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [PRESS_W-1:0]   lower_thr_reg, lower_thr_next;
    logic [PRESS_W-1:0]   upper_thr_reg, upper_thr_next;
    logic                 in_contact_reg, in_contact_next;
    logic [TIME_W-1:0]    strike_time_reg, strike_time_next;
    logic [TIME_W-1:0]    step_period_reg, step_period_next;
    logic [TIME_W-1:0]    elapsed_reg, elapsed_next;
    logic                 strike_reg, strike_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [PHASE_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [PRESS_W-1:0]   pressure;
    logic [TIME_W-1:0]    now;
    logic                 contact_c;
    logic                 strike_c;
    logic                 accept;
    logic [REM_W-1:0]     scaled;
    logic [REM_W:0]       rem_dbl;
    logic [REM_W:0]       div_sh;
    logic [REM_W:0]       rem_sub;
    logic                 rem_ge;

    assign pressure = s_tdata[PRESS_W-1:0];
    assign now      = s_tdata[PRESS_W +: TIME_W];
    assign accept   = s_tvalid && s_tready;

    assign contact_c = in_contact_reg ? (pressure > lower_thr_reg) : (pressure > upper_thr_reg);
    assign strike_c  = contact_c && !in_contact_reg;

    assign scaled  = REM_W'(elapsed_reg) * REM_W'(PHASE_SCALE);
    assign rem_dbl = {rem_reg, 1'b0};
    assign div_sh  = {1'b0, step_period_reg, SCALE_W'(0)};
    assign rem_ge  = rem_dbl >= div_sh;
    assign rem_sub = rem_dbl - div_sh;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next       = state_reg;
        lower_thr_next   = lower_thr_reg;
        upper_thr_next   = upper_thr_reg;
        in_contact_next  = in_contact_reg;
        strike_time_next = strike_time_reg;
        step_period_next = step_period_reg;
        elapsed_next     = elapsed_reg;
        strike_next      = strike_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_LOWER_THR: lower_thr_next = cfg_wdata;
                REG_UPPER_THR: upper_thr_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    in_contact_next = contact_c;
                    strike_next     = strike_c;
                    if (strike_c) begin
                        step_period_next = now - strike_time_reg;
                        strike_time_next = now;
                        elapsed_next     = '0;
                    end else begin
                        elapsed_next     = now - strike_time_reg;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (step_period_reg == '0 || elapsed_reg >= step_period_reg) begin
                    quo_next   = PHASE_FULL;
                    state_next = ST_DONE;
                end else begin
                    rem_next   = scaled;
                    quo_next   = '0;
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = rem_ge ? rem_sub[REM_W-1:0] : rem_dbl[REM_W-1:0];
                quo_next = {quo_reg[PHASE_W-2:0], rem_ge};
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_TDATA_W - PHASE_W - 2 - TIME_W)'(0), step_period_reg,
                                     strike_reg, in_contact_reg, quo_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            lower_thr_reg   <= LOWER_THR_RST;
            upper_thr_reg   <= UPPER_THR_RST;
            in_contact_reg  <= 1'b0;
            strike_time_reg <= '0;
            step_period_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            lower_thr_reg   <= lower_thr_next;
            upper_thr_reg   <= upper_thr_next;
            in_contact_reg  <= in_contact_next;
            strike_time_reg <= strike_time_next;
            step_period_reg <= step_period_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elapsed_reg <= elapsed_next;
        strike_reg  <= strike_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[PHASE_W-1:0] <= PHASE_FULL))
        else $error("phase beyond full scale");

    a_strike_in_contact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[PHASE_W+1] || m_tdata[PHASE_W]))
        else $error("strike without contact");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another in work");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < div_sh))
        else $error("divider remainder out of range");

    a_strike_resets_elapsed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && strike_reg) |-> (elapsed_reg == '0))
        else $error("elapsed time not cleared on strike");
`endif

endmodule

`default_nettype wire
